// File: sv/fbm_pkg.sv
// Shared constants, types and the control store of the block-map translator.
// Used by fbm_meta, flash_block_map_translator and fbm_checker; no dependencies.
package fbm_pkg;

  // Geometry
  localparam int DATA_BLOCKS   = 64;
  localparam int PAGES_PER_BLK = 16;
  localparam int PHYS_BLOCKS   = DATA_BLOCKS + 1;
  localparam int TOTAL_SECT    = DATA_BLOCKS * PAGES_PER_BLK;

  // Widths
  localparam int LSN_W  = 12;
  localparam int ADDR_W = 11;
  localparam int LBN_W  = $clog2(DATA_BLOCKS);
  localparam int PBN_W  = $clog2(PHYS_BLOCKS);
  localparam int OFF_W  = $clog2(PAGES_PER_BLK);

  typedef logic [LBN_W-1:0]         lbn_t;
  typedef logic [PBN_W-1:0]         pbn_t;
  typedef logic [OFF_W-1:0]         off_t;
  typedef logic [PAGES_PER_BLK-1:0] pmask_t;

  // Flash command codes
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_ERASE = 2'd2,
    CMD_ERROR = 2'd3
  } cmd_e;

  // Microcode step addresses
  typedef enum logic [3:0] {
    ST_FETCH,
    ST_MAP,
    ST_PW,
    ST_RD,
    ST_WR,
    ST_CP_RD,
    ST_CP_WR,
    ST_CP_WH,
    ST_ERASE,
    ST_ERR
  } step_e;

  // Branch kinds
  typedef enum logic [2:0] {
    BR_NEXT,
    BR_RANGE,
    BR_DISPATCH,
    BR_SKIP,
    BR_LOOP
  } br_e;

  // Address source for an issued command
  typedef enum logic [1:0] {
    AS_ZERO,
    AS_PBN_PAGE,
    AS_FB_PAGE,
    AS_PBN_BLK
  } asel_e;

  // Page source
  typedef enum logic {
    PS_OFF,
    PS_CNT
  } psel_e;

  // Written-bitmap update
  typedef enum logic [1:0] {
    PW_NONE,
    PW_SET_PBN,
    PW_SET_FB,
    PW_CLR_PBN
  } pwop_e;

  // One control word
  typedef struct packed {
    logic  wait_in;
    logic  lat_pbn;
    logic  lat_pw;
    logic  emit;
    cmd_e  cmd;
    logic  host;
    logic  last;
    asel_e asel;
    psel_e psel;
    pwop_e pwop;
    logic  swap;
    logic  cnt_inc;
    br_e   br;
    step_e nxt;
    step_e alt;
    step_e far;
  } ctrl_t;

  // Requests to the metadata stores
  typedef struct packed {
    logic   map_re;
    lbn_t   map_ra;
    logic   map_we;
    lbn_t   map_wa;
    pbn_t   map_wd;
    logic   pw_re;
    pbn_t   pw_ra;
    logic   pw_we;
    pbn_t   pw_wa;
    pmask_t pw_wd;
  } meta_req_t;

  // Control store
  function automatic ctrl_t ucode(input step_e s);
    ctrl_t c;
    c      = '0;
    c.cmd  = CMD_READ;
    c.asel = AS_ZERO;
    c.psel = PS_OFF;
    c.pwop = PW_NONE;
    c.br   = BR_NEXT;
    c.nxt  = ST_FETCH;
    c.alt  = ST_FETCH;
    c.far  = ST_FETCH;
    case (s)
      ST_FETCH: begin
        c.wait_in = 1'b1;
        c.br      = BR_RANGE;
        c.nxt     = ST_MAP;
        c.alt     = ST_ERR;
      end
      ST_MAP: begin
        c.lat_pbn = 1'b1;
        c.nxt     = ST_PW;
      end
      ST_PW: begin
        c.lat_pw = 1'b1;
        c.br     = BR_DISPATCH;
        c.nxt    = ST_RD;
        c.alt    = ST_WR;
        c.far    = ST_CP_RD;
      end
      ST_RD: begin
        c.emit = 1'b1;
        c.cmd  = CMD_READ;
        c.asel = AS_PBN_PAGE;
        c.last = 1'b1;
      end
      ST_WR: begin
        c.emit = 1'b1;
        c.cmd  = CMD_WRITE;
        c.asel = AS_PBN_PAGE;
        c.host = 1'b1;
        c.last = 1'b1;
        c.pwop = PW_SET_PBN;
      end
      ST_CP_RD: begin
        c.emit = 1'b1;
        c.cmd  = CMD_READ;
        c.asel = AS_PBN_PAGE;
        c.psel = PS_CNT;
        c.br   = BR_SKIP;
        c.nxt  = ST_CP_WR;
        c.alt  = ST_CP_WH;
      end
      ST_CP_WR: begin
        c.emit    = 1'b1;
        c.cmd     = CMD_WRITE;
        c.asel    = AS_FB_PAGE;
        c.psel    = PS_CNT;
        c.cnt_inc = 1'b1;
        c.br      = BR_LOOP;
        c.nxt     = ST_CP_RD;
        c.alt     = ST_ERASE;
      end
      ST_CP_WH: begin
        c.emit    = 1'b1;
        c.cmd     = CMD_WRITE;
        c.asel    = AS_FB_PAGE;
        c.psel    = PS_CNT;
        c.host    = 1'b1;
        c.pwop    = PW_SET_FB;
        c.cnt_inc = 1'b1;
        c.br      = BR_LOOP;
        c.nxt     = ST_CP_RD;
        c.alt     = ST_ERASE;
      end
      ST_ERASE: begin
        c.emit = 1'b1;
        c.cmd  = CMD_ERASE;
        c.asel = AS_PBN_BLK;
        c.last = 1'b1;
        c.pwop = PW_CLR_PBN;
        c.swap = 1'b1;
      end
      ST_ERR: begin
        c.emit = 1'b1;
        c.cmd  = CMD_ERROR;
        c.last = 1'b1;
      end
      default: begin
        c.nxt = ST_FETCH;
      end
    endcase
    return c;
  endfunction

endpackage

// File: sv/fbm_meta.sv
// Metadata stores: logical-to-physical block map and per-page written bitmap.
// Depends on fbm_pkg. Unwritten map entries read as identity, bitmap rows as zero.
module fbm_meta (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fbm_pkg::meta_req_t req_i,
  output fbm_pkg::pbn_t     map_rdata_o,
  output fbm_pkg::pmask_t   pw_rdata_o
);

  fbm_pkg::pbn_t   map_mem [fbm_pkg::DATA_BLOCKS];
  fbm_pkg::pmask_t pw_mem  [fbm_pkg::PHYS_BLOCKS];

  logic [fbm_pkg::DATA_BLOCKS-1:0] map_vld_q;
  logic [fbm_pkg::PHYS_BLOCKS-1:0] pw_vld_q;

  fbm_pkg::pbn_t   map_rd_q;
  fbm_pkg::lbn_t   map_ra_q;
  logic            map_hit_q;
  fbm_pkg::pmask_t pw_rd_q;
  logic            pw_hit_q;

  // Track which entries have been written since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_vld_q <= '0;
      pw_vld_q  <= '0;
    end else begin
      if (req_i.map_we) map_vld_q[req_i.map_wa] <= 1'b1;
      if (req_i.pw_we)  pw_vld_q[req_i.pw_wa]   <= 1'b1;
    end
  end

  // Write and read both stores, read data registered
  always_ff @(posedge clk_i) begin
    if (req_i.map_we) map_mem[req_i.map_wa] <= req_i.map_wd;
    if (req_i.map_re) begin
      map_rd_q  <= map_mem[req_i.map_ra];
      map_hit_q <= map_vld_q[req_i.map_ra];
      map_ra_q  <= req_i.map_ra;
    end
    if (req_i.pw_we) pw_mem[req_i.pw_wa] <= req_i.pw_wd;
    if (req_i.pw_re) begin
      pw_rd_q  <= pw_mem[req_i.pw_ra];
      pw_hit_q <= pw_vld_q[req_i.pw_ra];
    end
  end

  // Substitute reset contents for entries never written
  assign map_rdata_o = map_hit_q ? map_rd_q : fbm_pkg::PBN_W'(map_ra_q);
  assign pw_rdata_o  = pw_hit_q ? pw_rd_q : '0;

endmodule

// File: sv/flash_block_map_translator.sv
// Top level of the block-mapped flash translator: microcoded sequencer and datapath.
// Depends on fbm_pkg and fbm_meta.
//
// Usage: the input channel (in_valid_i/in_ready_o) takes one request word:
// mode_i (0 read, 1 write) and the logical sector lsn_i. The output channel
// (out_valid_o/out_ready_i) returns the flash commands of that request, one
// word each: command_o, address_o, host_data_o and last_o, which marks the
// final command of the request.
// A read or a first write of a page gives its one command; an out-of-range
// sector gives a single error word.
// An overwrite gives 32 words (15 read/write pairs, the host write and the
// erase), with one idle step at the rewritten page. The next request can be
// taken in the cycle after the last word is issued. A single sequencer that
// issues at most one command per cycle sets the rate. Reset clears the map to
// identity, the spare block to the last physical block and every written bit;
// it needs no clearing pass. When the receiver stalls, the result word holds in
// the output register and the sequencer waits on its next command.
module flash_block_map_translator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        mode_i,
  input  logic [fbm_pkg::LSN_W-1:0]   lsn_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  command_o,
  output logic [fbm_pkg::ADDR_W-1:0]  address_o,
  output logic                        host_data_o,
  output logic                        last_o
);

  fbm_pkg::step_e  step_q, step_d;
  fbm_pkg::ctrl_t  ctrl;
  fbm_pkg::off_t   cnt_q;
  fbm_pkg::pbn_t   free_q;
  logic            out_valid_q;

  logic            mode_q;
  fbm_pkg::lbn_t   lbn_q;
  fbm_pkg::off_t   off_q;
  fbm_pkg::pbn_t   pbn_q;
  fbm_pkg::pmask_t pw_q;

  fbm_pkg::cmd_e                 cmd_q;
  logic [fbm_pkg::ADDR_W-1:0]    addr_q;
  logic                          host_q;
  logic                          last_q;

  fbm_pkg::meta_req_t meta_req;
  fbm_pkg::pbn_t      map_rdata;
  fbm_pkg::pmask_t    pw_rdata;

  logic            accept, in_range, skip_hit, loop_end, written;
  logic            emit_now, emit_ok, go;
  fbm_pkg::lbn_t   lbn_in;
  fbm_pkg::off_t   off_in;
  fbm_pkg::pmask_t bit_mask;
  fbm_pkg::off_t   page;
  fbm_pkg::pbn_t   blk;
  logic [fbm_pkg::ADDR_W-1:0] addr_d;

  // Decode the current control word
  assign ctrl = fbm_pkg::ucode(step_q);

  assign in_ready_o = ctrl.wait_in;
  assign accept     = in_valid_i && ctrl.wait_in;
  assign in_range   = 32'(lsn_i) < 32'(fbm_pkg::TOTAL_SECT);
  assign lbn_in     = fbm_pkg::LBN_W'(lsn_i / fbm_pkg::PAGES_PER_BLK);
  assign off_in     = fbm_pkg::OFF_W'(lsn_i % fbm_pkg::PAGES_PER_BLK);

  assign bit_mask = fbm_pkg::pmask_t'(1) << off_q;
  assign skip_hit = (cnt_q == off_q);
  assign loop_end = (cnt_q == fbm_pkg::OFF_W'(fbm_pkg::PAGES_PER_BLK - 1));
  assign written  = pw_rdata[off_q];

  // Issue and advance conditions
  assign emit_now = ctrl.emit && !(ctrl.br == fbm_pkg::BR_SKIP && skip_hit);
  assign emit_ok  = !out_valid_q || out_ready_i;
  assign go       = (!ctrl.wait_in || in_valid_i) && (!emit_now || emit_ok);

  // Pick the next step
  always_comb begin
    step_d = step_q;
    if (go) begin
      case (ctrl.br)
        fbm_pkg::BR_NEXT:     step_d = ctrl.nxt;
        fbm_pkg::BR_RANGE:    step_d = in_range ? ctrl.nxt : ctrl.alt;
        fbm_pkg::BR_DISPATCH: begin
          if (!mode_q)      step_d = ctrl.nxt;
          else if (written) step_d = ctrl.far;
          else              step_d = ctrl.alt;
        end
        fbm_pkg::BR_SKIP:     step_d = skip_hit ? ctrl.alt : ctrl.nxt;
        fbm_pkg::BR_LOOP:     step_d = loop_end ? ctrl.alt : ctrl.nxt;
        default:              step_d = fbm_pkg::ST_FETCH;
      endcase
    end
  end

  // Form the command address
  assign page = (ctrl.psel == fbm_pkg::PS_CNT) ? cnt_q : off_q;
  assign blk  = (ctrl.asel == fbm_pkg::AS_FB_PAGE) ? free_q : pbn_q;

  always_comb begin
    case (ctrl.asel)
      fbm_pkg::AS_PBN_PAGE,
      fbm_pkg::AS_FB_PAGE: addr_d = fbm_pkg::ADDR_W'(32'(blk) * fbm_pkg::PAGES_PER_BLK
                                                     + 32'(page));
      fbm_pkg::AS_PBN_BLK: addr_d = fbm_pkg::ADDR_W'(pbn_q);
      default:             addr_d = '0;
    endcase
  end

  // Drive the metadata stores
  always_comb begin
    meta_req        = '0;
    meta_req.map_re = accept;
    meta_req.map_ra = lbn_in;
    meta_req.map_we = go && ctrl.swap;
    meta_req.map_wa = lbn_q;
    meta_req.map_wd = free_q;
    meta_req.pw_re  = go && ctrl.lat_pbn;
    meta_req.pw_ra  = map_rdata;
    meta_req.pw_we  = go && (ctrl.pwop != fbm_pkg::PW_NONE);
    meta_req.pw_wa  = (ctrl.pwop == fbm_pkg::PW_SET_FB) ? free_q : pbn_q;
    meta_req.pw_wd  = (ctrl.pwop == fbm_pkg::PW_CLR_PBN) ? '0 : (pw_q | bit_mask);
  end

  fbm_meta u_meta (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (meta_req),
    .map_rdata_o (map_rdata),
    .pw_rdata_o  (pw_rdata)
  );

  // Hold step, page counter, spare block and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= fbm_pkg::ST_FETCH;
      cnt_q       <= '0;
      free_q      <= fbm_pkg::PBN_W'(fbm_pkg::DATA_BLOCKS);
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (accept) begin
        cnt_q <= '0;
      end else if (go && ctrl.cnt_inc) begin
        cnt_q <= cnt_q + fbm_pkg::OFF_W'(1);
      end
      if (go && ctrl.swap) free_q <= pbn_q;
      if (go && emit_now) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Latch request fields, looked-up metadata and the output word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      lbn_q  <= lbn_in;
      off_q  <= off_in;
    end
    if (go && ctrl.lat_pbn) pbn_q <= map_rdata;
    if (go && ctrl.lat_pw)  pw_q  <= pw_rdata;
    if (go && emit_now) begin
      cmd_q  <= ctrl.cmd;
      addr_q <= addr_d;
      host_q <= ctrl.host;
      last_q <= ctrl.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign command_o   = cmd_q;
  assign address_o   = addr_q;
  assign host_data_o = host_q;
  assign last_o      = last_q;

endmodule

// File: sv/fbm_checker.sv
// Port-level checker for flash_block_map_translator, attached with bind.
// Depends on fbm_pkg.
module fbm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       mode_i,
  input logic [fbm_pkg::LSN_W-1:0]  lsn_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [1:0]                 command_o,
  input logic [fbm_pkg::ADDR_W-1:0] address_o,
  input logic                       host_data_o,
  input logic                       last_o
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(command_o)
      && $stable(address_o) && $stable(host_data_o) && $stable(last_o))
    else $error("result word changed while stalled");

  // An error word is a lone final word with zero address
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_o == fbm_pkg::CMD_ERROR |->
      last_o && address_o == '0 && !host_data_o)
    else $error("malformed error word");

  // Host data only feeds page writes
  a_host_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && host_data_o |-> command_o == fbm_pkg::CMD_WRITE)
    else $error("host data flagged on a non-write command");

  // No new request while a request still has words to come
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input ready in the middle of a request");

endmodule

bind flash_block_map_translator fbm_checker u_fbm_checker (.*);

// File: tb/sv/tb_flash_block_map_translator.sv
// Self-checking testbench for flash_block_map_translator: request driver, command monitor
// and a block-map predictor. Depends on fbm_pkg and the translator RTL only.
module tb_flash_block_map_translator;
  timeunit 1ns;
  timeprecision 1ps;

  import fbm_pkg::*;

  // One expected flash command word
  typedef struct packed {
    cmd_e              command;
    logic [ADDR_W-1:0] address;
    logic              host_data;
    logic              last;
  } flash_cmd_t;

  // One pending request word; drain marks a pause until all commands are in
  typedef struct packed {
    logic             mode;
    logic [LSN_W-1:0] lsn;
    logic             drain;
  } request_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic              mode_i      = 1'b0;
  logic [LSN_W-1:0]  lsn_i       = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [1:0]        command_o;
  logic [ADDR_W-1:0] address_o;
  logic              host_data_o;
  logic              last_o;

  request_t   req_q[$];
  flash_cmd_t exp_cmd_q[$];

  // Predictor copy of the translation state
  pbn_t   blk_map [DATA_BLOCKS];
  pbn_t   spare_blk;
  pmask_t page_used [PHYS_BLOCKS];

  int  error_cnt   = 0;
  bit  word_taken  = 1'b0;
  int  burst_left  = 0;
  int  gap_left    = 0;
  int  ready_left  = 0;

  flash_block_map_translator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .lsn_i       (lsn_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .command_o   (command_o),
    .address_o   (address_o),
    .host_data_o (host_data_o),
    .last_o      (last_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    error_cnt++;
  endtask

  function automatic logic [ADDR_W-1:0] page_addr(input pbn_t blk, input int page);
    return ADDR_W'(int'(blk) * PAGES_PER_BLK + page);
  endfunction

  function automatic void push_cmd(input cmd_e c, input logic [ADDR_W-1:0] a,
                                   input logic h, input logic l);
    flash_cmd_t w;
    w.command   = c;
    w.address   = a;
    w.host_data = h;
    w.last      = l;
    exp_cmd_q.push_back(w);
  endfunction

  // Work out the flash commands of one request and update the map
  function automatic void translate_request(input logic mode, input logic [LSN_W-1:0] lsn);
    lbn_t   lbn;
    off_t   off;
    pbn_t   pbn;
    pbn_t   fb;
    pmask_t bit_m;
    int     pg;
    if (lsn >= TOTAL_SECT) begin
      push_cmd(CMD_ERROR, '0, 1'b0, 1'b1);
      return;
    end
    lbn   = lbn_t'(lsn / PAGES_PER_BLK);
    off   = off_t'(lsn % PAGES_PER_BLK);
    pbn   = blk_map[lbn];
    fb    = spare_blk;
    bit_m = pmask_t'(1) << off;
    if (!mode) begin
      push_cmd(CMD_READ, page_addr(pbn, off), 1'b0, 1'b1);
    end else if ((page_used[pbn] & bit_m) == '0) begin
      push_cmd(CMD_WRITE, page_addr(pbn, off), 1'b1, 1'b1);
      page_used[pbn] |= bit_m;
    end else begin
      // Rebuild the block in the spare, then erase and swap
      for (pg = 0; pg < PAGES_PER_BLK; pg++) begin
        if (pg != off) begin
          push_cmd(CMD_READ, page_addr(pbn, pg), 1'b0, 1'b0);
          push_cmd(CMD_WRITE, page_addr(fb, pg), 1'b0, 1'b0);
        end else begin
          push_cmd(CMD_WRITE, page_addr(fb, pg), 1'b1, 1'b0);
        end
      end
      push_cmd(CMD_ERASE, ADDR_W'(pbn), 1'b0, 1'b1);
      page_used[fb]  = page_used[pbn] | bit_m;
      page_used[pbn] = '0;
      blk_map[lbn]   = fb;
      spare_blk      = pbn;
    end
  endfunction

  task automatic add_request(input logic mode, input int lsn);
    request_t r;
    r.mode  = mode;
    r.lsn   = LSN_W'(lsn);
    r.drain = 1'b0;
    req_q.push_back(r);
  endtask

  task automatic add_drain();
    request_t r;
    r       = '0;
    r.drain = 1'b1;
    req_q.push_back(r);
  endtask

  // Predict on accepted requests, check accepted command words
  always @(posedge clk_i) begin : monitor
    flash_cmd_t want;
    if (rst_ni) begin
      word_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) translate_request(mode_i, lsn_i);
      if (out_valid_o && out_ready_i) begin
        if (exp_cmd_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word cmd=%0d addr=%0d host=%0d last=%0d",
                                    command_o, address_o, host_data_o, last_o));
        end else begin
          want = exp_cmd_q.pop_front();
          if (command_o !== want.command)
            report_mismatch($sformatf("command %0d, want %0d", command_o, want.command));
          if (address_o !== want.address)
            report_mismatch($sformatf("address %0d, want %0d", address_o, want.address));
          if (host_data_o !== want.host_data)
            report_mismatch($sformatf("host_data %0d, want %0d", host_data_o,
                                      want.host_data));
          if (last_o !== want.last)
            report_mismatch($sformatf("last %0d, want %0d", last_o, want.last));
        end
      end
    end
  end

  // Send request words in bursts with random gaps; hold until accepted
  always @(negedge clk_i) begin : driver
    request_t nxt;
    logic     next_valid;
    if (rst_ni && !(in_valid_i && !word_taken)) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (req_q.size() > 0) begin
        if (req_q[0].drain) begin
          // Pause until every command of earlier requests has come back
          if (exp_cmd_q.size() == 0 && !in_valid_i) nxt = req_q.pop_front();
        end else begin
          nxt        = req_q.pop_front();
          mode_i     <= nxt.mode;
          lsn_i      <= nxt.lsn;
          next_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(0, 12);
          end
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // Stall the command channel in runs of random length
  always @(negedge clk_i) begin : receiver
    if (rst_ni) begin
      if (ready_left > 0) begin
        ready_left--;
      end else if (out_ready_i) begin
        out_ready_i <= 1'b0;
        ready_left  = ($urandom_range(0, 7) == 0) ? 20 : $urandom_range(0, 6);
      end else begin
        out_ready_i <= 1'b1;
        ready_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(0, 10);
      end
    end
  end

  initial begin : stimulus
    int n;
    int pick;
    int lbn;
    int page;
    logic md;
    for (n = 0; n < DATA_BLOCKS; n++) blk_map[n] = pbn_t'(n);
    for (n = 0; n < PHYS_BLOCKS; n++) page_used[n] = '0;
    spare_blk = pbn_t'(DATA_BLOCKS);

    // Directed: first writes, overwrites with copy, range edges and errors
    add_request(1'b0, 0);
    add_request(1'b1, 0);
    add_request(1'b1, 0);
    add_request(1'b0, 0);
    add_request(1'b1, 15);
    add_request(1'b1, 15);
    add_request(1'b1, 1);
    add_request(1'b1, 1);
    add_request(1'b0, TOTAL_SECT - 1);
    add_request(1'b1, TOTAL_SECT - 1);
    add_request(1'b1, TOTAL_SECT - 1);
    add_request(1'b0, TOTAL_SECT);
    add_request(1'b1, TOTAL_SECT);
    add_request(1'b1, 4095);
    add_request(1'b0, 4095);
    add_request(1'b0, 2048);
    add_request(1'b1, 'h555);
    add_request(1'b0, 'hAAA);
    add_request(1'b1, 511);
    add_request(1'b0, 511);
    add_drain();

    // Random: mostly in-range traffic on a few hot blocks, some noise
    for (n = 0; n < 290; n++) begin
      pick = $urandom_range(0, 99);
      md   = ($urandom_range(0, 99) < 60);
      if (pick < 8) begin
        add_request(md, $urandom_range(TOTAL_SECT, 4095));
      end else if (pick < 14) begin
        add_request(md, $urandom_range(0, 4095));
      end else begin
        case ($urandom_range(0, 3))
          0:       lbn = $urandom_range(0, DATA_BLOCKS - 1);
          1:       lbn = 0;
          2:       lbn = DATA_BLOCKS - 1;
          default: lbn = $urandom_range(1, 2);
        endcase
        page = ($urandom_range(0, 2) == 0) ? $urandom_range(0, PAGES_PER_BLK - 1)
                                           : $urandom_range(0, 3);
        add_request(md, lbn * PAGES_PER_BLK + page);
      end
      if (n == 100 || n == 200) add_drain();
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for all requests to go out and all commands to come back
    while (req_q.size() > 0 || in_valid_i || exp_cmd_q.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (error_cnt == 0 && exp_cmd_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(4_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule

// File: files.f
sv/fbm_pkg.sv
sv/fbm_meta.sv
sv/flash_block_map_translator.sv
sv/fbm_checker.sv
tb/sv/tb_flash_block_map_translator.sv
